// File: rtl/core/ii2pl_pkg.sv
// Package for the interval index to position/length mapper.
// Holds sequencer states, mode, status and register index codes, reset lengths and widths. No dependencies.
package ii2pl_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_NORM,
        ST_MUL_TRI,
        ST_APP_WR,
        ST_MAP_RD,
        ST_MAP_EVAL,
        ST_MAP_DIV,
        ST_MAP_WALK,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_MAP    = 2'd1,
        MODE_REWIND = 2'd2,
        MODE_NOP    = 2'd3
    } mode_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_BEYOND   = 2'd2;
    localparam logic [1:0] STATUS_BACKWARD = 2'd3;

    localparam logic [1:0] REG_MIN_LEN = 2'd0;
    localparam logic [1:0] REG_MAX_LEN = 2'd1;

    localparam logic [15:0] MIN_LEN_RESET = 16'd100;
    localparam logic [15:0] MAX_LEN_RESET = 16'd500;

    localparam int POS_W = 40;
    localparam int LEN_W = 16;
    localparam int VAL_W = 48;
    localparam int W_W   = 17;

endpackage

// File: rtl/core/interval_index_to_position_length.sv
// Interval index to position/length mapper: top level with sequencer and datapath.
// Depends on ii2pl_pkg.
//
// One item is taken at a time; s_ready is high only while the sequencer is idle.
// Rewind and no-op go straight to the output state. An append to a full table returns
// STATUS_FULL without a write; an append whose contig has no full-width positions
// writes its entry at once, and any other append first runs two shift-add
// multiplications by W at one multiplier bit per cycle through a shared accumulator.
// A map reads the table memory once for each contig it examines, until it finds one
// or stops with a status, then either runs a one-bit-per-cycle restoring divider by W
// over COUNT_WIDTH quotient bits or walks the end-region positions one by one, and
// then enters the output state. A result sits in an output register until taken; the
// next item is accepted once it has moved there.
module interval_index_to_position_length #(
    parameter int MAX_CONTIGS = 64,
    parameter int COUNT_WIDTH = 48
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic [ii2pl_pkg::VAL_W-1:0] s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ii2pl_pkg::POS_W-1:0] m_position,
    output logic [ii2pl_pkg::LEN_W-1:0] m_fragment_length,
    output logic [ii2pl_pkg::VAL_W-1:0] m_total_intervals,
    output logic [1:0]                  m_status,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [15:0]                 cfg_data
);
    import ii2pl_pkg::*;

    localparam int CW     = COUNT_WIDTH;
    localparam int ACC_W  = CW + 2;
    localparam int PTR_W  = $clog2(MAX_CONTIGS + 1);
    localparam int AW     = (MAX_CONTIGS > 1) ? $clog2(MAX_CONTIGS) : 1;
    localparam int CMP_W  = (CW > VAL_W) ? CW : VAL_W;
    localparam int DCNT_W = $clog2(CW + 1);

    typedef struct packed {
        logic [CW-1:0]    first_int;
        logic [POS_W-1:0] first_pos;
        logic [CW-1:0]    er_int;
        logic [POS_W-1:0] er_pos;
        logic [CW-1:0]    last_int;
        logic             empty;
    } entry_t;

    entry_t mem [MAX_CONTIGS];
    entry_t rd_q;
    entry_t wr_entry;

    state_t state_reg, state_next;

    logic [15:0]       min_reg, max_reg;
    logic [CW-1:0]     run_cnt_reg, run_cnt_next;
    logic [POS_W-1:0]  run_pos_reg, run_pos_next;
    logic [PTR_W-1:0]  count_reg, count_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [VAL_W-1:0]  n_reg, n_next;
    logic [PTR_W-1:0]  p_reg, p_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  opa_reg, opa_next;
    logic [W_W-1:0]    opb_reg, opb_next;
    logic [CW-1:0]     first_reg, first_next;
    logic [CW-1:0]     er_int_reg, er_int_next;
    logic [POS_W-1:0]  er_pos_reg, er_pos_next;
    logic [CW-1:0]     loc_reg, loc_next;
    logic [W_W-1:0]    rem_reg, rem_next;
    logic [W_W-1:0]    c_reg, c_next;
    logic [POS_W-1:0]  wpos_reg, wpos_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic [POS_W-1:0]  res_pos_reg, res_pos_next;
    logic [LEN_W-1:0]  res_len_reg, res_len_next;
    logic [VAL_W-1:0]  res_tot_reg, res_tot_next;
    logic [1:0]        res_st_reg, res_st_next;
    logic              m_valid_reg;
    logic [POS_W-1:0]  m_position_reg;
    logic [LEN_W-1:0]  m_fragment_length_reg;
    logic [VAL_W-1:0]  m_total_intervals_reg;
    logic [1:0]        m_status_reg;

    logic [15:0]      eff_max;
    logic [W_W-1:0]   w;
    logic [VAL_W:0]   len_p1;
    logic [VAL_W:0]   normal;
    logic             has_normal;
    logic             accept;
    logic             out_free;
    logic             full;
    logic             mul_done;
    logic             mem_we;
    logic [CW-1:0]    cnt_final;
    logic [W_W:0]     div_t;
    logic             div_ge;
    logic             hit_skip;

    assign eff_max    = (max_reg < min_reg) ? min_reg : max_reg;
    assign w          = W_W'(eff_max) - W_W'(min_reg) + W_W'(1);
    assign len_p1     = {1'b0, n_reg} + (VAL_W+1)'(1);
    assign has_normal = len_p1 >= (VAL_W+1)'(eff_max);
    assign normal     = len_p1 - (VAL_W+1)'(eff_max);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign full       = count_reg == PTR_W'(MAX_CONTIGS);
    assign mul_done   = opb_reg == '0;
    assign cnt_final  = acc_reg[CW-1:0];
    assign div_t      = {rem_reg, loc_reg[CW-1]};
    assign div_ge     = div_t >= (W_W+1)'(w);
    assign hit_skip   = rd_q.empty || (CMP_W'(n_reg) > CMP_W'(rd_q.last_int));
    assign mem_we     = (state_reg == ST_APP_WR) && !full && (acc_reg != '1);

    assign s_ready   = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_position        = m_position_reg;
    assign m_fragment_length = m_fragment_length_reg;
    assign m_total_intervals = m_total_intervals_reg;
    assign m_status          = m_status_reg;

    always_comb begin
        wr_entry.first_int = first_reg;
        wr_entry.first_pos = run_pos_reg;
        wr_entry.er_int    = er_int_reg;
        wr_entry.er_pos    = er_pos_reg;
        wr_entry.last_int  = cnt_final - CW'(1);
        wr_entry.empty     = cnt_final == first_reg;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg[AW-1:0]] <= wr_entry;
        end
        rd_q <= mem[p_reg[AW-1:0]];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode_t'(s_mode))
                        MODE_APPEND: state_next = ST_APP_WR;
                        MODE_MAP:    state_next = ST_MAP_RD;
                        default:     state_next = ST_OUT;
                    endcase
                end
            end
            ST_APP_WR: begin
                if (full) begin
                    state_next = ST_OUT;
                end else if (acc_reg == '1) begin
                    state_next = has_normal ? ST_MUL_NORM : ST_APP_WR;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL_NORM: if (mul_done) state_next = ST_MUL_TRI;
            ST_MUL_TRI:  if (mul_done) state_next = ST_APP_WR;
            ST_MAP_RD: begin
                if (CMP_W'(n_reg) >= CMP_W'(run_cnt_reg) || p_reg >= count_reg) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MAP_EVAL;
                end
            end
            ST_MAP_EVAL: begin
                if (hit_skip) begin
                    state_next = ST_MAP_RD;
                end else if (CMP_W'(n_reg) < CMP_W'(rd_q.first_int)) begin
                    state_next = ST_OUT;
                end else if (CMP_W'(n_reg) < CMP_W'(rd_q.er_int)) begin
                    state_next = ST_MAP_DIV;
                end else begin
                    state_next = ST_MAP_WALK;
                end
            end
            ST_MAP_DIV: if (dcnt_reg == '0) state_next = ST_OUT;
            ST_MAP_WALK: begin
                if (c_reg == '0 || CW'(c_reg) > loc_reg) state_next = ST_OUT;
            end
            ST_OUT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    // acc_reg all ones on entry to ST_APP_WR marks a fresh append; setup replaces it with the running count.
    always_comb begin
        run_cnt_next = run_cnt_reg;
        run_pos_next = run_pos_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        n_next       = n_reg;
        p_next       = p_reg;
        acc_next     = acc_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        first_next   = first_reg;
        er_int_next  = er_int_reg;
        er_pos_next  = er_pos_reg;
        loc_next     = loc_reg;
        rem_next     = rem_reg;
        c_next       = c_reg;
        wpos_next    = wpos_reg;
        dcnt_next    = dcnt_reg;
        res_pos_next = res_pos_reg;
        res_len_next = res_len_reg;
        res_tot_next = res_tot_reg;
        res_st_next  = res_st_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    n_next       = s_value;
                    p_next       = PTR_W'(ptr_reg);
                    acc_next     = '1;
                    res_pos_next = '0;
                    res_len_next = '0;
                    res_tot_next = '0;
                    res_st_next  = STATUS_OK;
                    if (mode_t'(s_mode) == MODE_REWIND) begin
                        ptr_next = '0;
                    end
                end
            end
            ST_APP_WR: begin
                if (full) begin
                    res_st_next  = STATUS_FULL;
                    res_tot_next = VAL_W'(run_cnt_reg);
                end else if (acc_reg == '1) begin
                    first_next  = run_cnt_reg;
                    er_int_next = run_cnt_reg;
                    er_pos_next = run_pos_reg;
                    acc_next    = ACC_W'(run_cnt_reg);
                    if (has_normal) begin
                        opa_next    = ACC_W'(normal);
                        opb_next    = w;
                        er_pos_next = run_pos_reg + POS_W'(normal);
                    end
                end else begin
                    // entry written this cycle; commit the append
                    run_cnt_next = cnt_final;
                    run_pos_next = run_pos_reg + n_reg[POS_W-1:0];
                    count_next   = count_reg + PTR_W'(1);
                    res_tot_next = VAL_W'(cnt_final);
                end
            end
            ST_MUL_NORM: begin
                if (mul_done) begin
                    er_int_next = acc_reg[CW-1:0];
                    acc_next    = '0;
                    opa_next    = ACC_W'(w - W_W'(1));
                    opb_next    = w;
                end else begin
                    acc_next = acc_reg + (opb_reg[0] ? opa_reg : '0);
                    opa_next = opa_reg << 1;
                    opb_next = opb_reg >> 1;
                end
            end
            ST_MUL_TRI: begin
                if (mul_done) begin
                    acc_next = ACC_W'(er_int_reg + acc_reg[CW:1]);
                end else begin
                    acc_next = acc_reg + (opb_reg[0] ? opa_reg : '0);
                    opa_next = opa_reg << 1;
                    opb_next = opb_reg >> 1;
                end
            end
            ST_MAP_RD: begin
                if (CMP_W'(n_reg) >= CMP_W'(run_cnt_reg) || p_reg >= count_reg) begin
                    res_st_next = STATUS_BEYOND;
                end
            end
            ST_MAP_EVAL: begin
                if (hit_skip) begin
                    p_next = p_reg + PTR_W'(1);
                end else if (CMP_W'(n_reg) < CMP_W'(rd_q.first_int)) begin
                    res_st_next = STATUS_BACKWARD;
                end else if (CMP_W'(n_reg) < CMP_W'(rd_q.er_int)) begin
                    loc_next  = CW'(n_reg) - rd_q.first_int;
                    rem_next  = '0;
                    dcnt_next = DCNT_W'(CW);
                    wpos_next = rd_q.first_pos;
                end else begin
                    loc_next  = CW'(n_reg) - rd_q.er_int;
                    c_next    = w - W_W'(1);
                    wpos_next = rd_q.er_pos;
                end
            end
            ST_MAP_DIV: begin
                if (dcnt_reg == '0) begin
                    res_pos_next = wpos_reg + POS_W'(loc_reg);
                    res_len_next = min_reg + rem_reg[LEN_W-1:0];
                    ptr_next     = p_reg[AW-1:0];
                end else begin
                    rem_next  = div_ge ? W_W'(div_t - (W_W+1)'(w)) : div_t[W_W-1:0];
                    loc_next  = {loc_reg[CW-2:0], div_ge};
                    dcnt_next = dcnt_reg - DCNT_W'(1);
                end
            end
            ST_MAP_WALK: begin
                if (c_reg == '0) begin
                    res_st_next = STATUS_BEYOND;
                end else if (CW'(c_reg) > loc_reg) begin
                    res_pos_next = wpos_reg;
                    res_len_next = min_reg + loc_reg[LEN_W-1:0];
                    ptr_next     = p_reg[AW-1:0];
                end else begin
                    loc_next  = loc_reg - CW'(c_reg);
                    c_next    = c_reg - W_W'(1);
                    wpos_next = wpos_reg + POS_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            min_reg     <= MIN_LEN_RESET;
            max_reg     <= MAX_LEN_RESET;
            run_cnt_reg <= '0;
            run_pos_reg <= '0;
            count_reg   <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            run_cnt_reg <= run_cnt_next;
            run_pos_reg <= run_pos_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_MIN_LEN) min_reg <= cfg_data;
                if (cfg_index == REG_MAX_LEN) max_reg <= cfg_data;
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        opa_reg    <= opa_next;
        opb_reg    <= opb_next;
        first_reg  <= first_next;
        er_int_reg <= er_int_next;
        er_pos_reg <= er_pos_next;
        loc_reg    <= loc_next;
        rem_reg    <= rem_next;
        c_reg      <= c_next;
        wpos_reg   <= wpos_next;
        dcnt_reg   <= dcnt_next;
        res_pos_reg <= res_pos_next;
        res_len_reg <= res_len_next;
        res_tot_reg <= res_tot_next;
        res_st_reg  <= res_st_next;
        if (state_reg == ST_OUT && out_free) begin
            m_position_reg        <= res_pos_reg;
            m_fragment_length_reg <= res_len_reg;
            m_total_intervals_reg <= res_tot_reg;
            m_status_reg          <= res_st_reg;
        end
    end

endmodule

// File: rtl/core/ii2pl_checker.sv
// Port-level checker for the interval index to position/length mapper.
// Depends on ii2pl_pkg; bound to interval_index_to_position_length below.
module ii2pl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [39:0] m_position,
    input logic [15:0] m_fragment_length,
    input logic [47:0] m_total_intervals,
    input logic [1:0]  m_status
);
    import ii2pl_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped before transfer");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while previous still in work");

    a_fail_no_map: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != STATUS_OK |-> m_position == '0 && m_fragment_length == '0)
        else $error("mapping fields set on failed result");

    a_total_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_total_intervals != '0 |-> m_position == '0 && m_fragment_length == '0)
        else $error("append result carries mapping fields");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind interval_index_to_position_length ii2pl_checker u_ii2pl_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_valid           (s_valid),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_position        (m_position),
    .m_fragment_length (m_fragment_length),
    .m_total_intervals (m_total_intervals),
    .m_status          (m_status)
);
